FILE: rtl/table_driven_dfa_recognizer_top_assert.svh
// ----------------------------------------------------------------------------
// DFA recognizer assertion macros
// Concurrent property wrappers used by the recognizer top module.
// ----------------------------------------------------------------------------
`ifndef TABLE_DRIVEN_DFA_RECOGNIZER_TOP_ASSERT_SVH
`define TABLE_DRIVEN_DFA_RECOGNIZER_TOP_ASSERT_SVH

`ifndef SYNTHESIS
// Same-cycle implication under an active-low reset.
`define TDFA_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("tdfa assertion failed");
// Next-cycle implication under an active-low reset.
`define TDFA_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("tdfa assertion failed");
`else
`define TDFA_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define TDFA_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif

`endif

FILE: rtl/tdfa_pkg.sv
// ----------------------------------------------------------------------------
// DFA recognizer package
// Sizes, transaction mode codes and the match result type.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package tdfa_pkg;

  localparam int STATE_W    = 6;
  localparam int MAX_STATES = 64;
  localparam int CHAR_W     = 8;
  localparam int SYM_W      = 4;
  localparam int ALPHA_SIZE = 16;
  localparam int LEN_W      = 5;
  localparam int MODE_W     = 3;

  // Alphabet is searched one row of LANES entries per cycle.
  localparam int LANES  = 4;
  localparam int LANE_W = 2;
  localparam int GROUPS = ALPHA_SIZE / LANES;
  localparam int GRP_W  = SYM_W - LANE_W;

  localparam int TT_DEPTH = MAX_STATES * ALPHA_SIZE;
  localparam int TT_AW    = STATE_W + SYM_W;

  localparam logic [MODE_W-1:0] MODE_LOAD_ALPHA = 3'd0;
  localparam logic [MODE_W-1:0] MODE_LOAD_TRANS = 3'd1;
  localparam logic [MODE_W-1:0] MODE_LOAD_MARK  = 3'd2;
  localparam logic [MODE_W-1:0] MODE_CHAR       = 3'd3;
  localparam logic [MODE_W-1:0] MODE_END_WORD   = 3'd4;

  typedef logic [LANES-1:0][CHAR_W-1:0] alpha_row_t;

  typedef struct packed {
    logic             hit;
    logic [SYM_W-1:0] sym;
  } match_t;

endpackage

FILE: rtl/tdfa_alpha_store.sv
// ----------------------------------------------------------------------------
// DFA recognizer alphabet store
// Sixteen characters kept as rows of four; one byte write, one row read.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tdfa_alpha_store (
  input  logic                         clk,
  input  logic                         wr_en,
  input  logic [tdfa_pkg::SYM_W-1:0]   wr_sym,
  input  logic [tdfa_pkg::CHAR_W-1:0]  wr_char,
  input  logic [tdfa_pkg::GRP_W-1:0]   rd_grp,
  output tdfa_pkg::alpha_row_t         rd_row
);
  import tdfa_pkg::*;

  alpha_row_t mem [GROUPS];
  alpha_row_t rd_row_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_sym[SYM_W-1:LANE_W]][wr_sym[LANE_W-1:0]] <= wr_char;
    end
  end

  always_ff @(posedge clk) begin
    rd_row_r <= mem[rd_grp];
  end

  assign rd_row = rd_row_r;

endmodule

FILE: rtl/tdfa_match_unit.sv
// ----------------------------------------------------------------------------
// DFA recognizer match unit
// Compare one alphabet row against a character; report the first hit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tdfa_match_unit (
  input  tdfa_pkg::alpha_row_t         row,
  input  logic [tdfa_pkg::GRP_W-1:0]   grp,
  input  logic [tdfa_pkg::CHAR_W-1:0]  ch,
  input  logic [tdfa_pkg::LEN_W-1:0]   limit,
  output tdfa_pkg::match_t             match
);
  import tdfa_pkg::*;

  logic [LEN_W-1:0] base;

  assign base = LEN_W'({grp, LANE_W'(0)});

  // Scan lanes from the top down so the lowest matching lane wins.
  always_comb begin
    match.hit = 1'b0;
    match.sym = '0;
    for (int i = LANES - 1; i >= 0; i--) begin
      if (((base + LEN_W'(i)) < limit) && (row[i] == ch)) begin
        match.hit = 1'b1;
        match.sym = {grp, LANE_W'(i)};
      end
    end
  end

endmodule

FILE: rtl/tdfa_trans_ram.sv
// ----------------------------------------------------------------------------
// DFA recognizer transition table
// Next state per state and symbol; one write port, one registered read.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tdfa_trans_ram (
  input  logic                          clk,
  input  logic                          wr_en,
  input  logic [tdfa_pkg::TT_AW-1:0]    wr_addr,
  input  logic [tdfa_pkg::STATE_W-1:0]  wr_data,
  input  logic [tdfa_pkg::TT_AW-1:0]    rd_addr,
  output logic [tdfa_pkg::STATE_W-1:0]  rd_data
);
  import tdfa_pkg::*;

  logic [STATE_W-1:0] mem [TT_DEPTH];
  logic [STATE_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

FILE: rtl/table_driven_dfa_recognizer_top.sv
// ----------------------------------------------------------------------------
// Table-driven DFA recognizer
// Programmable automaton: loads alphabet, transitions and accept marks, then
// steps through characters and reports accept or reject at end of word.
// ----------------------------------------------------------------------------
//
//   Channel  Direction  Handshake            Payload
//   in_      input      in_valid/in_ready    mode, char_code, state_index,
//                                            symbol_index, next_state, accept_bit
//   out_     output     out_valid/out_ready  accepted_word, final_state,
//                                            unknown_symbol
//   cfg_     input      cfg_we               cfg_wdata (alphabet_length)
//
// Load transactions and unused modes complete in the idle state. A character
// steps through the registered alphabet rows that the shared 4-lane match
// unit scans (at least one, at most ceil(min(alphabet_length,16)/4)), then
// through the transition-table read on a hit. End of word passes through a
// registered accept-mark read and waits while a previous result is still
// held on out_.
// Reset is synchronous, active low; it clears the state, error flag, accept
// marks (through per-state valid bits) and alphabet_length. in_ready is
// high only while the sequencer is idle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module table_driven_dfa_recognizer_top (
  input  logic                          clk,
  input  logic                          rst_n,
  // configuration
  input  logic                          cfg_we,
  input  logic [tdfa_pkg::LEN_W-1:0]    cfg_wdata,
  // input transactions
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [tdfa_pkg::MODE_W-1:0]   in_mode,
  input  logic [tdfa_pkg::CHAR_W-1:0]   in_char_code,
  input  logic [tdfa_pkg::STATE_W-1:0]  in_state_index,
  input  logic [tdfa_pkg::SYM_W-1:0]    in_symbol_index,
  input  logic [tdfa_pkg::STATE_W-1:0]  in_next_state,
  input  logic                          in_accept_bit,
  // result transactions
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          out_accepted_word,
  output logic [tdfa_pkg::STATE_W-1:0]  out_final_state,
  output logic                          out_unknown_symbol
);
  import tdfa_pkg::*;

`include "table_driven_dfa_recognizer_top_assert.svh"

  // Sequencer states
  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_SCAN  = 2'd1;
  localparam logic [1:0] ST_TRANS = 2'd2;
  localparam logic [1:0] ST_EOW   = 2'd3;

  logic [1:0]         state_r, state_nxt;
  logic [LEN_W-1:0]   len_r;
  logic [STATE_W-1:0] cur_r, cur_nxt;
  logic               err_r, err_nxt;
  logic [CHAR_W-1:0]  char_r, char_nxt;
  logic [GRP_W-1:0]   grp_r, grp_nxt;

  logic               out_valid_r, out_valid_nxt;
  logic               out_acc_r, out_acc_nxt;
  logic [STATE_W-1:0] out_state_r, out_state_nxt;
  logic               out_unk_r, out_unk_nxt;

  // Accept marks: memory plus per-state valid bits cleared by reset.
  logic                  mark_mem [MAX_STATES];
  logic [MAX_STATES-1:0] mark_vld_r;
  logic                  mark_rd_r;
  logic                  mark_vld_rd_r;

  logic               in_acc;
  logic               ld_out;
  logic [LEN_W-1:0]   n_search;
  logic [GRP_W:0]     n_grp;
  logic [GRP_W:0]     grp_inc;
  alpha_row_t         alpha_row;
  match_t             mt;
  logic [STATE_W-1:0] tt_rdata;

  assign in_ready = (state_r == ST_IDLE);
  assign in_acc   = in_valid && in_ready;

  // Clamp the searched length and count rows to scan.
  assign n_search = (len_r > LEN_W'(ALPHA_SIZE)) ? LEN_W'(ALPHA_SIZE) : len_r;
  assign n_grp    = (GRP_W+1)'((n_search + LEN_W'(LANES - 1)) >> LANE_W);
  assign grp_inc  = {1'b0, grp_r} + (GRP_W+1)'(1);

  // Alphabet row read is issued ahead from the next row index, so the registered row matches grp_r.
  tdfa_alpha_store u_alpha (
    .clk     (clk),
    .wr_en   (in_acc && (in_mode == MODE_LOAD_ALPHA)),
    .wr_sym  (in_symbol_index),
    .wr_char (in_char_code),
    .rd_grp  (grp_nxt),
    .rd_row  (alpha_row)
  );

  tdfa_match_unit u_match (
    .row   (alpha_row),
    .grp   (grp_r),
    .ch    (char_r),
    .limit (n_search),
    .match (mt)
  );

  // All field values fit the table, so every transition load is in range.
  tdfa_trans_ram u_trans (
    .clk     (clk),
    .wr_en   (in_acc && (in_mode == MODE_LOAD_TRANS)),
    .wr_addr ({in_state_index, in_symbol_index}),
    .wr_data (in_next_state),
    .rd_addr ({cur_r, mt.sym}),
    .rd_data (tt_rdata)
  );

  always_ff @(posedge clk) begin
    if (in_acc && (in_mode == MODE_LOAD_MARK)) begin
      mark_mem[in_state_index] <= in_accept_bit;
    end
    mark_rd_r <= mark_mem[cur_r];
  end

  // Sequencer and output register
  always_comb begin
    state_nxt     = state_r;
    cur_nxt       = cur_r;
    err_nxt       = err_r;
    char_nxt      = char_r;
    grp_nxt       = grp_r;
    ld_out        = 1'b0;
    out_acc_nxt   = out_acc_r;
    out_state_nxt = out_state_r;
    out_unk_nxt   = out_unk_r;

    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          if (in_mode == MODE_CHAR) begin
            // Start the alphabet scan at row zero.
            char_nxt  = in_char_code;
            grp_nxt   = '0;
            state_nxt = ST_SCAN;
          end else if (in_mode == MODE_END_WORD) begin
            state_nxt = ST_EOW;
          end
        end
      end
      ST_SCAN: begin
        if (mt.hit) begin
          state_nxt = ST_TRANS;
        end else if (grp_inc >= n_grp) begin
          // Character not in the alphabet: flag and hold the state.
          err_nxt   = 1'b1;
          state_nxt = ST_IDLE;
        end else begin
          grp_nxt = grp_inc[GRP_W-1:0];
        end
      end
      ST_TRANS: begin
        cur_nxt   = tt_rdata;
        state_nxt = ST_IDLE;
      end
      ST_EOW: begin
        // Hold until the output register is free.
        if (!out_valid_r || out_ready) begin
          ld_out        = 1'b1;
          out_acc_nxt   = mark_vld_rd_r && mark_rd_r && !err_r;
          out_state_nxt = cur_r;
          out_unk_nxt   = err_r;
          cur_nxt       = '0;
          err_nxt       = 1'b0;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    out_valid_nxt = ld_out || (out_valid_r && !out_ready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      len_r         <= '0;
      cur_r         <= '0;
      err_r         <= 1'b0;
      grp_r         <= '0;
      out_valid_r   <= 1'b0;
      mark_vld_r    <= '0;
      mark_vld_rd_r <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      cur_r         <= cur_nxt;
      err_r         <= err_nxt;
      grp_r         <= grp_nxt;
      out_valid_r   <= out_valid_nxt;
      mark_vld_rd_r <= mark_vld_r[cur_r];
      if (cfg_we) begin
        len_r <= cfg_wdata;
      end
      if (in_acc && (in_mode == MODE_LOAD_MARK)) begin
        mark_vld_r[in_state_index] <= 1'b1;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    char_r      <= char_nxt;
    out_acc_r   <= out_acc_nxt;
    out_state_r <= out_state_nxt;
    out_unk_r   <= out_unk_nxt;
  end

  assign out_valid          = out_valid_r;
  assign out_accepted_word  = out_acc_r;
  assign out_final_state    = out_state_r;
  assign out_unknown_symbol = out_unk_r;

  // A result load returns the automaton to the start state.
  `TDFA_ASSERT_NXT(a_eow_resets_state, clk, rst_n, ld_out, (cur_r == '0) && !err_r)
  // An accepted word never carries the unknown-symbol flag.
  `TDFA_ASSERT_IMP(a_acc_no_unknown, clk, rst_n, out_valid && out_accepted_word, !out_unknown_symbol)
  // The transition read follows only a scan hit.
  `TDFA_ASSERT_IMP(a_trans_after_scan, clk, rst_n, state_r == ST_TRANS, $past(state_r) == ST_SCAN && $past(mt.hit))
  // The scan never walks past the last row to search.
  `TDFA_ASSERT_IMP(a_scan_in_range, clk, rst_n, state_r == ST_SCAN, (n_grp == '0) || ({1'b0, grp_r} < n_grp))

endmodule
